FILE: rtl/met_pkg.sv
// met_pkg: widths, types and fixed-point helpers for the escape-time block
// no dependencies; imported by the interfaces and every module

package met_pkg;

    localparam int LANES     = 4;
    localparam int FRAC_BITS = 28;

    localparam int IN_W    = 32;
    localparam int IN_FRAC = 28;
    localparam int CNT_W   = 16;
    localparam int Z_W     = FRAC_BITS + 8;
    localparam int MUL_W   = FRAC_BITS + 2;
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int UP      = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
    localparam int DOWN    = (FRAC_BITS < IN_FRAC) ? (IN_FRAC - FRAC_BITS) : 0;

    localparam int MAX_ITER_RESET = 256;

    typedef logic signed [IN_W-1:0]  t_coord;
    typedef logic signed [Z_W-1:0]   t_z;
    typedef logic signed [MUL_W-1:0] t_mop;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [LANE_W-1:0]       t_lane;
    typedef logic [LANES-1:0]        t_mask;

    localparam t_z TWO      = t_z'(1) <<< (FRAC_BITS + 1);
    localparam t_z NEG_TWO  = -TWO;
    localparam t_z FOUR     = t_z'(4) <<< FRAC_BITS;

    // Q4.28 input to internal Q8.FRAC_BITS, floor on a right shift
    function automatic t_z to_internal(input t_coord raw);
        logic signed [63:0] v;
        v = 64'(raw);
        if (FRAC_BITS >= IN_FRAC) begin
            v = v <<< UP;
        end else begin
            v = v >>> DOWN;
        end
        return v[Z_W-1:0];
    endfunction

endpackage

FILE: rtl/met_pt_if.sv
// met_pt_if, met_cnt_if: point and count channels with valid/ready
// depends on met_pkg

interface met_pt_if import met_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord c_real_0;
    t_coord c_imag_0;
    t_coord c_real_1;
    t_coord c_imag_1;
    t_coord c_real_2;
    t_coord c_imag_2;
    t_coord c_real_3;
    t_coord c_imag_3;

    modport source (
        output valid, c_real_0, c_imag_0, c_real_1, c_imag_1,
               c_real_2, c_imag_2, c_real_3, c_imag_3,
        input  ready
    );
    modport sink (
        input  valid, c_real_0, c_imag_0, c_real_1, c_imag_1,
               c_real_2, c_imag_2, c_real_3, c_imag_3,
        output ready
    );
endinterface

interface met_cnt_if import met_pkg::*; ();
    logic   valid;
    logic   ready;
    t_count count_0;
    t_count count_1;
    t_count count_2;
    t_count count_3;

    modport source (
        output valid, count_0, count_1, count_2, count_3,
        input  ready
    );
    modport sink (
        input  valid, count_0, count_1, count_2, count_3,
        output ready
    );
endinterface

FILE: rtl/met_mul.sv
// met_mul: shared signed multiplier, product truncated to Q.FRAC_BITS, registered
// depends on met_pkg

module met_mul import met_pkg::*; (
    input  logic i_clk,
    input  t_mop i_a,
    input  t_mop i_b,
    output t_z   o_prod
);

    logic signed [2*MUL_W-1:0] w_full;
    logic signed [2*MUL_W-1:0] w_shift;
    t_z                        n_prod;
    t_z                        r_prod;

    assign w_full  = i_a * i_b;
    assign w_shift = w_full >>> FRAC_BITS;
    assign n_prod  = w_shift[Z_W-1:0];

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/mandelbrot_escape_time_lanes_unit.sv
// mandelbrot_escape_time_lanes_unit: four-lane escape-time counter, one shared multiplier
// depends on met_pkg, met_pt_if, met_cnt_if, met_mul
// per group: ST_IDLE, then per iteration ST_NEXT and for each lane in turn ST_RI; a live lane
//   goes on to ST_NEW, ST_SQR, ST_SQI, ST_CHK, one failing the bound test stops at ST_NEW
// a new group is taken only in ST_IDLE; the next group is accepted while a result waits
// reset: synchronous active low; max_iteration returns to 256, control state cleared

module mandelbrot_escape_time_lanes_unit import met_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  t_count i_cfg_wdata,
    met_pt_if.sink    i_pt,
    met_cnt_if.source o_cnt
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NEXT = 3'd1;
    localparam logic [2:0] ST_RI   = 3'd2;
    localparam logic [2:0] ST_NEW  = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_SQI  = 3'd5;
    localparam logic [2:0] ST_CHK  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [2:0] r_state, n_state;
    t_lane      r_lane, n_lane;
    t_count     r_iter, n_iter;
    t_mask      r_active, n_active;
    t_count     r_max_iter;
    logic       r_out_valid, n_out_valid;

    t_z     r_cr [LANES];
    t_z     r_ci [LANES];
    t_z     r_zr [LANES];
    t_z     r_zi [LANES];
    t_z     r_rr [LANES];
    t_z     r_ii [LANES];
    t_count r_count [LANES];
    t_count r_out [LANES];

    t_coord w_in_re [4];
    t_coord w_in_im [4];
    t_mop   w_a, w_b;
    t_z     w_prod;
    t_z     w_nzr, w_nzi, w_sum;
    logic   w_escape;
    logic   w_lane_done;
    logic   w_load;
    logic   w_start;

    assign w_in_re = '{i_pt.c_real_0, i_pt.c_real_1, i_pt.c_real_2, i_pt.c_real_3};
    assign w_in_im = '{i_pt.c_imag_0, i_pt.c_imag_1, i_pt.c_imag_2, i_pt.c_imag_3};

    assign i_pt.ready = (r_state == ST_IDLE);
    assign w_start    = i_pt.valid && (r_state == ST_IDLE);
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || o_cnt.ready);

    // operand select for the shared multiplier
    always_comb begin
        w_a = r_zi[r_lane][MUL_W-1:0];
        w_b = r_zi[r_lane][MUL_W-1:0];
        if (r_state == ST_RI) begin
            w_a = r_zr[r_lane][MUL_W-1:0];
        end else if (r_state == ST_SQR) begin
            w_a = r_zr[r_lane][MUL_W-1:0];
            w_b = r_zr[r_lane][MUL_W-1:0];
        end
    end

    met_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_nzr    = r_rr[r_lane] - r_ii[r_lane] + r_cr[r_lane];
    assign w_nzi    = (w_prod <<< 1) + r_ci[r_lane];
    assign w_escape = (w_nzr >= TWO) || (w_nzr <= NEG_TWO) ||
                      (w_nzi >= TWO) || (w_nzi <= NEG_TWO);
    assign w_sum    = r_rr[r_lane] + w_prod;

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_iter      = r_iter;
        n_active    = r_active;
        w_lane_done = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pt.valid) begin
                    n_state  = ST_NEXT;
                    n_iter   = '0;
                    n_active = '1;
                end
            end
            ST_NEXT: begin
                if ((r_iter < r_max_iter) && (|r_active)) begin
                    n_lane  = '0;
                    n_state = ST_RI;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RI: begin
                if (r_active[r_lane]) begin
                    n_state = ST_NEW;
                end else begin
                    w_lane_done = 1'b1;
                end
            end
            ST_NEW: begin
                if (w_escape) begin
                    n_active[r_lane] = 1'b0;
                    w_lane_done      = 1'b1;
                end else begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: n_state = ST_SQI;
            ST_SQI: n_state = ST_CHK;
            ST_CHK: begin
                if (w_sum >= FOUR) begin
                    n_active[r_lane] = 1'b0;
                end
                w_lane_done = 1'b1;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_lane_done) begin
            if (r_lane == t_lane'(LANES - 1)) begin
                n_iter  = r_iter + t_count'(1);
                n_state = ST_NEXT;
            end else begin
                n_lane  = r_lane + t_lane'(1);
                n_state = ST_RI;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cnt.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lane      <= '0;
            r_iter      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_max_iter  <= t_count'(MAX_ITER_RESET);
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_iter      <= n_iter;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_iter <= i_cfg_wdata;
            end
        end
    end

    // lane payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            for (int k = 0; k < LANES; k++) begin
                r_cr[k]    <= to_internal(w_in_re[k]);
                r_ci[k]    <= to_internal(w_in_im[k]);
                r_zr[k]    <= '0;
                r_zi[k]    <= '0;
                r_rr[k]    <= '0;
                r_ii[k]    <= '0;
                r_count[k] <= '0;
            end
        end
        if (r_state == ST_NEW) begin
            r_zr[r_lane]    <= w_nzr;
            r_zi[r_lane]    <= w_nzi;
            r_count[r_lane] <= r_count[r_lane] + t_count'(1);
        end
        if (r_state == ST_SQI) begin
            r_rr[r_lane] <= w_prod;
        end
        if (r_state == ST_CHK) begin
            r_ii[r_lane] <= w_prod;
        end
        if (w_load) begin
            for (int k = 0; k < LANES; k++) begin
                r_out[k] <= r_count[k];
            end
        end
    end

    assign o_cnt.valid   = r_out_valid;
    assign o_cnt.count_0 = r_out[0];

    generate
        if (LANES > 1) begin : g_cnt1
            assign o_cnt.count_1 = r_out[1];
        end else begin : g_cnt1_off
            assign o_cnt.count_1 = '0;
        end
        if (LANES > 2) begin : g_cnt2
            assign o_cnt.count_2 = r_out[2];
        end else begin : g_cnt2_off
            assign o_cnt.count_2 = '0;
        end
        if (LANES > 3) begin : g_cnt3
            assign o_cnt.count_3 = r_out[3];
        end else begin : g_cnt3_off
            assign o_cnt.count_3 = '0;
        end
    endgenerate

endmodule
